/* rtl/fxp_alu_pkg.sv */
// Package for the Q24.8 fixed-point arithmetic unit.
// Holds opcode and status codes and width constants; no dependencies.
package fxp_alu_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned FracBitsDefault = 8;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_MIN = 4'd4,
		OP_MAX = 4'd5,
		OP_INC = 4'd6,
		OP_DEC = 4'd7,
		OP_I2F = 4'd8,
		OP_F2I = 4'd9
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_OVF = 2'd1,
		ST_DIVZ = 2'd2
	} status_t;

endpackage

/* rtl/fxp_alu_div.sv */
// Pipelined restoring divider for magnitudes: one quotient bit per stage.
// Depends on fxp_alu_pkg. Carries a sideband tag with every item.
module fxp_alu_div
	import fxp_alu_pkg::*;
#(
	parameter int unsigned NumW = 48,
	parameter int unsigned DenW = 32,
	parameter int unsigned TagW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [NumW-1:0] num,
	input  logic [DenW-1:0] den,
	input  logic [TagW-1:0] tag_in,
	output logic            out_valid,
	output logic [NumW-1:0] quo,
	output logic [DenW:0]   rem,
	output logic [DenW-1:0] den_out,
	output logic [TagW-1:0] tag_out
);

	// Stage k holds the partial remainder and the unconsumed numerator bits.
	logic            v_q   [NumW+1];
	logic [NumW-1:0] n_q   [NumW+1];
	logic [DenW:0]   r_q   [NumW+1];
	logic [DenW-1:0] d_q   [NumW+1];
	logic [TagW-1:0] t_q   [NumW+1];

	always_comb begin
		v_q[0] = in_valid;
		n_q[0] = num;
		r_q[0] = '0;
		d_q[0] = den;
		t_q[0] = tag_in;
	end

	for (genvar k = 0; k < NumW; k++) begin : g_stage
		logic [DenW+1:0] sh;
		logic [DenW+1:0] diff;
		assign sh = {r_q[k], n_q[k][NumW-1]};
		assign diff = sh - {2'b00, d_q[k]};

		// Valid bits clear on reset; payload follows without reset.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end

		// One shift and subtract step; quotient bit enters at the bottom.
		always_ff @(posedge clk) begin
			if (en) begin
				d_q[k+1] <= d_q[k];
				t_q[k+1] <= t_q[k];
				if (!diff[DenW+1]) begin
					r_q[k+1] <= diff[DenW:0];
					n_q[k+1] <= {n_q[k][NumW-2:0], 1'b1};
				end else begin
					r_q[k+1] <= sh[DenW:0];
					n_q[k+1] <= {n_q[k][NumW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_q[NumW];
	assign quo = n_q[NumW];
	assign rem = r_q[NumW];
	assign den_out = d_q[NumW];
	assign tag_out = t_q[NumW];

endmodule

/* rtl/fixed_point_q24_8_alu_core.sv */
// Top level of the Q24.8 fixed-point arithmetic unit.
// Depends on fxp_alu_pkg and fxp_alu_div.
//
// Usage: an operation transfers on the input channel when in_valid and
// in_ready are both high; its result transfers on the output channel when
// out_valid and out_ready are both high. One result leaves for every
// operation, in order.
// Path: the result of an operation passes two input stages, one divider
// stage per bit of the (32 + FRACTION_BITS)-bit numerator, and the
// output register before it is offered. All opcodes share that one
// pipeline so results stay in order.
// Throughput is one operation per cycle while the output is not stalled.
// The whole pipeline advances when the final register is empty or is being
// taken; when the receiver stalls with a full output, the pipeline holds and
// in_ready drops, so nothing is lost or repeated.
// Reset clears every valid bit; payload registers are not reset.
module fixed_point_q24_8_alu_core
	import fxp_alu_pkg::*;
#(
	parameter int unsigned FRACTION_BITS = FracBitsDefault
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [3:0]              opcode,
	input  logic signed [DataW-1:0] operand_a,
	input  logic signed [DataW-1:0] operand_b,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [DataW-1:0] result_value,
	output logic                    a_less,
	output logic                    a_equal,
	output logic                    a_greater,
	output logic [1:0]              status
);

	localparam int unsigned NumW = DataW + FRACTION_BITS;
	localparam int unsigned WideW = DataW + 2;
	localparam int unsigned PW = 2 * DataW;
	localparam logic signed [WideW-1:0] MaxW = WideW'(64'sd2147483647);
	localparam logic signed [WideW-1:0] MinW = -WideW'(64'sd2147483648);

	typedef struct packed {
		logic [3:0]       op;
		logic             lt;
		logic             eq;
		logic             gt;
		logic             neg;
		logic             simple_ovf;
		logic [DataW-1:0] simple_res;
		logic [PW-1:0]    prod_mag;
	} tag_t;

	logic adv;

	// Stage 1: register the operands.
	logic             v_s1;
	logic [3:0]       op_s1;
	logic signed [DataW-1:0] a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= opcode;
			a_s1 <= operand_a;
			b_s1 <= operand_b;
		end
	end

	// Stage 2: simple operations, compare flags, product and magnitudes.
	logic signed [WideW-1:0] sum_w;
	logic [DataW-1:0] simple_c;
	logic             sovf_c;
	logic             lt_c;
	logic [DataW-1:0] mag_a, mag_b;

	assign lt_c = a_s1 < b_s1;
	assign mag_a = a_s1[DataW-1] ? DataW'(-a_s1) : a_s1;
	assign mag_b = b_s1[DataW-1] ? DataW'(-b_s1) : b_s1;

	always_comb begin
		sum_w = '0;
		simple_c = '0;
		sovf_c = 1'b0;
		case (op_s1)
			OP_ADD: sum_w = WideW'(a_s1) + WideW'(b_s1);
			OP_SUB: sum_w = WideW'(a_s1) - WideW'(b_s1);
			OP_INC: sum_w = WideW'(a_s1) + WideW'(1);
			OP_DEC: sum_w = WideW'(a_s1) - WideW'(1);
			default: sum_w = '0;
		endcase
		case (op_s1) inside
			OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
				if (sum_w > MaxW) begin
					simple_c = DataW'(MaxW);
					sovf_c = 1'b1;
				end else if (sum_w < MinW) begin
					simple_c = DataW'(MinW);
					sovf_c = 1'b1;
				end else begin
					simple_c = sum_w[DataW-1:0];
				end
			end
			OP_MIN: simple_c = lt_c ? a_s1 : b_s1;
			OP_MAX: simple_c = (a_s1 > b_s1) ? a_s1 : b_s1;
			OP_I2F: begin
				// The bits shifted out must all equal the sign.
				if (a_s1 > (DataW'(MaxW) >>> FRACTION_BITS)) begin
					simple_c = DataW'(MaxW);
					sovf_c = 1'b1;
				end else if (a_s1 < (DataW'(MinW) >>> FRACTION_BITS)) begin
					simple_c = DataW'(MinW);
					sovf_c = 1'b1;
				end else begin
					simple_c = a_s1 <<< FRACTION_BITS;
				end
			end
			OP_F2I: simple_c = a_s1 >>> FRACTION_BITS;
			default: simple_c = '0;
		endcase
	end

	logic             v_s2;
	tag_t             tag_s2;
	logic [NumW-1:0]  num_s2;
	logic [DataW-1:0] den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2.op <= op_s1;
			tag_s2.lt <= lt_c;
			tag_s2.eq <= a_s1 == b_s1;
			tag_s2.gt <= a_s1 > b_s1;
			tag_s2.neg <= a_s1[DataW-1] ^ b_s1[DataW-1];
			tag_s2.simple_ovf <= sovf_c;
			tag_s2.simple_res <= simple_c;
			tag_s2.prod_mag <= PW'(mag_a) * PW'(mag_b);
			num_s2 <= {mag_a, FRACTION_BITS'(0)};
			den_s2 <= mag_b;
		end
	end

	// Division stages; all other results ride along in the tag.
	logic             v_d;
	logic [NumW-1:0]  quo_d;
	logic [DataW:0]   rem_d;
	logic [DataW-1:0] den_d;
	tag_t             tag_d;

	fxp_alu_div #(
		.NumW(NumW),
		.DenW(DataW),
		.TagW($bits(tag_t))
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_valid(v_s2),
		.num(num_s2),
		.den(den_s2),
		.tag_in(tag_s2),
		.out_valid(v_d),
		.quo(quo_d),
		.rem(rem_d),
		.den_out(den_d),
		.tag_out(tag_d)
	);

	// Stage 3: round the product and quotient and saturate by sign.
	logic [PW:0]     pr_c;
	logic [PW:0]     mag_c;
	logic [DataW+1:0] rem2;
	logic            up_c;
	logic [DataW-1:0] res_c;
	logic [1:0]      st_c;

	assign rem2 = {rem_d, 1'b0};
	assign up_c = rem2 >= {2'b00, den_d};

	always_comb begin
		pr_c = (PW+1)'(tag_d.prod_mag) + (PW+1)'(1 << (FRACTION_BITS - 1));
		mag_c = '0;
		res_c = tag_d.simple_res;
		st_c = tag_d.simple_ovf ? ST_OVF : ST_OK;
		case (tag_d.op) inside
			OP_MUL, OP_DIV: begin
				if (tag_d.op == OP_MUL) begin
					mag_c = pr_c >> FRACTION_BITS;
				end else begin
					mag_c = (PW+1)'(quo_d) + (PW+1)'(up_c);
				end
				if (tag_d.op == OP_DIV && den_d == '0) begin
					res_c = '0;
					st_c = ST_DIVZ;
				end else if (tag_d.neg && mag_c > (PW+1)'(64'd2147483648)) begin
					res_c = DataW'(MinW);
					st_c = ST_OVF;
				end else if (!tag_d.neg && mag_c > (PW+1)'(64'd2147483647)) begin
					res_c = DataW'(MaxW);
					st_c = ST_OVF;
				end else begin
					res_c = tag_d.neg ? DataW'(-mag_c) : mag_c[DataW-1:0];
					st_c = ST_OK;
				end
			end
			default: ;
		endcase
	end

	logic v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_value <= res_c;
			status <= st_c;
			a_less <= tag_d.lt;
			a_equal <= tag_d.eq;
			a_greater <= tag_d.gt;
		end
	end

	assign adv = !v_s3 || out_ready;
	assign in_ready = adv;
	assign out_valid = v_s3;

	// Pipeline holds while the output waits.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value))
		else $error("output changed while stalled");

	// Compare flags are mutually exclusive.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot({a_less, a_equal, a_greater}))
		else $error("compare flags not one-hot");

	// Divide by zero always gives zero.
	a_divz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DIVZ |-> result_value == '0)
		else $error("divide by zero result not zero");

	// Status never takes the unused code.
	a_stcode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("bad status code");

endmodule
